// ===== src/bffa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bffa_pkg;

    localparam int NUM_CELLS_DEF = 1024;

    localparam int MODE_W   = 1;
    localparam int COUNT_W  = 11;
    localparam int START_W  = 10;
    localparam int STATUS_W = 1;

    localparam logic [MODE_W-1:0]   MODE_ALLOC = 1'b0;
    localparam logic [MODE_W-1:0]   MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 1'b0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 1'b1;

    typedef struct packed {
        logic clear;
        logic load;
        logic setup_free;
        logic scan;
        logic mark;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic alloc;
        logic count_zero;
        logic free_skip;
        logic hit;
        logic miss;
        logic mark_last;
        logic clear_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/bffa_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bffa_req_if;
    logic                              valid;
    logic                              ready;
    logic [bffa_pkg::MODE_W-1:0]       mode;
    logic [bffa_pkg::COUNT_W-1:0]      cell_count;
    logic [bffa_pkg::START_W-1:0]      start_cell;

    modport source (output valid, output mode, output cell_count, output start_cell,
                    input ready);
    modport sink   (input valid, input mode, input cell_count, input start_cell,
                    output ready);
endinterface

`default_nettype wire

// ===== src/bffa_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bffa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [bffa_pkg::STATUS_W-1:0]     status;
    logic [bffa_pkg::START_W-1:0]      run_start;

    modport source (output valid, output status, output run_start, input ready);
    modport sink   (input valid, input status, input run_start, output ready);
endinterface

`default_nettype wire

// ===== src/bitmap_first_fit_allocator.sv =====
// Channel   Dir  Interface     Payload
// i_req     in   bffa_req_if   mode, cell_count, start_cell
// o_rsp     out  bffa_rsp_if   status, run_start
//
// One request is worked at a time; the cell map is a one-bit RAM walked one cell per cycle.
// Allocate of c cells scans the map from cell 0 until a free run of c cells is found, then
// marks that run; when no run fits, the whole map is scanned. Free of c cells clears them.
// After reset the map is cleared, and i_req.ready stays low until that is done.
// A finished result waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_first_fit_allocator #(
    parameter int NUM_CELLS = bffa_pkg::NUM_CELLS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bffa_req_if.sink   i_req,
    bffa_rsp_if.source o_rsp
);

    bffa_pkg::t_cmd cmd;
    bffa_pkg::t_sts sts;

    bffa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bffa_dp #(
        .NUM_CELLS (NUM_CELLS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

`default_nettype wire

// ===== src/bffa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bffa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = bffa_pkg::NUM_CELLS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/bffa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bffa_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    bffa_req_if.sink            i_req,
    input  wire bffa_pkg::t_sts i_sts,
    output bffa_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_sts.alloc) begin
                    n_state = i_sts.count_zero ? S_DONE : S_SCAN;
                end else if (i_sts.free_skip) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.setup_free = 1'b1;
                    n_state          = S_MARK;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_MARK;
                end else if (i_sts.miss) begin
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_sts.mark_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== src/bffa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bffa_dp #(
    parameter int NUM_CELLS = bffa_pkg::NUM_CELLS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    bffa_req_if.sink            i_req,
    bffa_rsp_if.source          o_rsp,
    input  wire bffa_pkg::t_cmd i_cmd,
    output bffa_pkg::t_sts      o_sts
);

    localparam int AW = $clog2(NUM_CELLS);
    localparam int PW = AW + 1;
    localparam int CW = bffa_pkg::COUNT_W;
    localparam int SW = bffa_pkg::START_W;
    localparam int KW = (PW > CW) ? PW : CW;
    localparam int EW = (PW > CW + 1) ? PW : CW + 1;
    localparam logic [PW-1:0] N_P = PW'(NUM_CELLS);
    localparam logic [EW-1:0] N_E = EW'(NUM_CELLS);

    logic                              r_mode;
    logic [CW-1:0]                     r_count;
    logic [SW-1:0]                     r_start;
    logic [PW-1:0]                     r_ptr;
    logic [PW-1:0]                     n_ptr;
    logic [PW-1:0]                     r_end;
    logic                              r_chk_vld;
    logic                              n_chk_vld;
    logic [AW-1:0]                     r_chk_idx;
    logic [KW-1:0]                     r_run;
    logic [bffa_pkg::STATUS_W-1:0]     r_res_status;
    logic [SW-1:0]                     r_res_start;
    logic                              r_out_vld;
    logic                              n_out_vld;
    logic [bffa_pkg::STATUS_W-1:0]     r_out_status;
    logic [SW-1:0]                     r_out_start;

    logic                              issue;
    logic                              hit;
    logic                              miss;
    logic [KW-1:0]                     run_nx;
    logic [EW-1:0]                     first_e;
    logic [EW-1:0]                     start_e;
    logic [EW-1:0]                     sum_e;
    logic [PW-1:0]                     end_p;
    logic                              ram_we;
    logic [0:0]                        ram_wdata;
    logic                              ram_re;
    logic [0:0]                        ram_q;

    assign issue   = (r_ptr < N_P);
    assign run_nx  = r_chk_vld ? (ram_q[0] ? '0 : r_run + KW'(1)) : r_run;
    assign hit     = r_chk_vld && !ram_q[0] && (run_nx == KW'(r_count));
    assign miss    = !hit && !issue;
    assign first_e = EW'(r_chk_idx) + EW'(1) - EW'(r_count);
    assign start_e = EW'(r_start);
    assign sum_e   = start_e + EW'(r_count);
    assign end_p   = (sum_e > N_E) ? N_P : sum_e[PW-1:0];

    assign ram_we    = i_cmd.clear || i_cmd.mark;
    assign ram_wdata = i_cmd.mark ? 1'(r_mode == bffa_pkg::MODE_ALLOC) : 1'b0;
    assign ram_re    = i_cmd.scan && issue;

    bffa_ram #(
        .WIDTH (1),
        .DEPTH (NUM_CELLS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_ptr     = r_ptr;
        n_chk_vld = r_chk_vld;
        n_out_vld = r_out_vld;
        if (i_cmd.load) begin
            n_ptr     = '0;
            n_chk_vld = 1'b0;
        end
        if (i_cmd.clear || i_cmd.mark) begin
            n_ptr = r_ptr + PW'(1);
        end
        if (i_cmd.setup_free) begin
            n_ptr = start_e[PW-1:0];
        end
        if (i_cmd.scan) begin
            if (hit) begin
                n_ptr     = first_e[PW-1:0];
                n_chk_vld = 1'b0;
            end else begin
                n_chk_vld = issue;
                if (issue) begin
                    n_ptr = r_ptr + PW'(1);
                end
            end
        end
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
        if (i_cmd.out_load) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_ptr     <= n_ptr;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode       <= i_req.mode;
            r_count      <= i_req.cell_count;
            r_start      <= i_req.start_cell;
            r_run        <= '0;
            r_res_status <= bffa_pkg::STATUS_OK;
            r_res_start  <= (i_req.mode == bffa_pkg::MODE_FREE) ? i_req.start_cell : '0;
        end
        if (i_cmd.setup_free) begin
            r_end <= end_p;
        end
        if (i_cmd.scan) begin
            r_chk_idx <= r_ptr[AW-1:0];
            r_run     <= run_nx;
            if (hit) begin
                r_end       <= PW'(r_chk_idx) + PW'(1);
                r_res_start <= first_e[SW-1:0];
            end else if (miss) begin
                r_res_status <= bffa_pkg::STATUS_NO_SPACE;
                r_res_start  <= '0;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_start  <= r_res_start;
        end
    end

    assign o_sts.alloc      = (r_mode == bffa_pkg::MODE_ALLOC);
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.free_skip  = (start_e >= N_E) || (r_count == '0);
    assign o_sts.hit        = hit;
    assign o_sts.miss       = miss;
    assign o_sts.mark_last  = ((r_ptr + PW'(1)) == r_end);
    assign o_sts.clear_last = (r_ptr == (N_P - PW'(1)));
    assign o_sts.out_free   = !r_out_vld || o_rsp.ready;

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.run_start = r_out_start;

endmodule

`default_nettype wire

// ===== src/bffa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bffa_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_req_valid,
    input wire logic                              i_req_ready,
    input wire logic                              i_rsp_valid,
    input wire logic                              i_rsp_ready,
    input wire logic [bffa_pkg::STATUS_W-1:0]     i_rsp_status,
    input wire logic [bffa_pkg::START_W-1:0]      i_rsp_run_start
);

    // Reset starts the map clearing, so nothing is offered or accepted right after it.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_rsp_valid && !i_req_ready))
        else $error("valid or ready high right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while another is in work");

    a_no_space_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status == bffa_pkg::STATUS_NO_SPACE)) |->
        (i_rsp_run_start == '0))
        else $error("failed allocate carries a nonzero start");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_run_start)))
        else $error("stalled response changed");

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_run_start (o_rsp.run_start)
);

`default_nettype wire

// ===== tb/tb_bitmap_first_fit_allocator.sv =====
`timescale 1ns / 1ps

module tb_bitmap_first_fit_allocator;
    import bffa_pkg::*;

    localparam int NUM_CELLS = NUM_CELLS_DEF;
    localparam int MAX_WAIT = 15;
    localparam longint TIMEOUT_NS = 8_000_000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  run_start;
    } t_alloc_result;

    typedef struct {
        int first;
        int len;
    } t_run_rec;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bffa_req_if req_ch ();
    bffa_rsp_if rsp_ch ();

    bitmap_first_fit_allocator #(
        .NUM_CELLS(NUM_CELLS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    bit            cell_busy [NUM_CELLS];
    t_alloc_result expected_replies[$];
    t_run_rec      live_runs[$];
    t_alloc_result last_result;
    t_alloc_result oldest_reply;
    bit            no_idle = 1'b0;
    int            fail_count = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_alloc_result apply_to_cell_map(input logic [MODE_W-1:0] mode,
                                                        input logic [COUNT_W-1:0] count,
                                                        input logic [START_W-1:0] start);
        t_alloc_result res;
        int run;
        int first;
        int limit;
        res.status = STATUS_OK;
        res.run_start = '0;
        if (mode == MODE_ALLOC) begin
            if (count != 0) begin
                res.status = STATUS_NO_SPACE;
                run = 0;
                for (int i = 0; i < NUM_CELLS; i++) begin
                    if (cell_busy[i]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == int'(count)) begin
                            first = i + 1 - int'(count);
                            for (int j = first; j <= i; j++) cell_busy[j] = 1'b1;
                            res.status = STATUS_OK;
                            res.run_start = first[START_W-1:0];
                            break;
                        end
                    end
                end
            end
        end else begin
            res.run_start = start;
            limit = int'(start) + int'(count);
            if (limit > NUM_CELLS) limit = NUM_CELLS;
            for (int j = int'(start); j < limit; j++) cell_busy[j] = 1'b0;
        end
        return res;
    endfunction

    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input int count,
                                input int start);
        int gap;
        logic [COUNT_W-1:0] cnt;
        logic [START_W-1:0] st;
        t_alloc_result res;
        t_run_rec rec;
        begin
            cnt = COUNT_W'(count);
            st = START_W'(start);
            gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge i_clk);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            req_ch.valid      <= 1'b1;
            req_ch.mode       <= mode;
            req_ch.cell_count <= cnt;
            req_ch.start_cell <= st;
            @(posedge i_clk);
            while (!req_ch.ready) @(posedge i_clk);
            res = apply_to_cell_map(mode, cnt, st);
            expected_replies.push_back(res);
            last_result = res;
            if (mode == MODE_ALLOC && res.status == STATUS_OK && cnt != 0) begin
                rec.first = int'(res.run_start);
                rec.len = int'(cnt);
                live_runs.push_back(rec);
            end
        end
    endtask

    task automatic wait_until_drained;
        begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            while (expected_replies.size() != 0) @(posedge i_clk);
        end
    endtask

    // Most requests allocate small runs or release runs handed out earlier.
    task automatic send_random_request;
        int pick;
        int idx;
        int k;
        int size;
        int first;
        t_run_rec rec;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || (pick < 85 && live_runs.size() == 0)) begin
                k = $urandom_range(0, 99);
                if (k < 70) size = $urandom_range(1, 16);
                else if (k < 90) size = $urandom_range(17, 128);
                else if (k < 97) size = $urandom_range(129, 1024);
                else if (k < 99) size = $urandom_range(1025, 2047);
                else size = 0;
                send_request(MODE_ALLOC, size, $urandom_range(0, 1023));
            end else if (pick < 85) begin
                idx = $urandom_range(0, live_runs.size() - 1);
                rec = live_runs[idx];
                first = rec.first;
                if (rec.len > 1 && $urandom_range(0, 3) == 0) begin
                    k = $urandom_range(1, rec.len - 1);
                    rec.first = rec.first + k;
                    rec.len = rec.len - k;
                    live_runs[idx] = rec;
                    send_request(MODE_FREE, k, first);
                end else begin
                    live_runs.delete(idx);
                    send_request(MODE_FREE, rec.len, first);
                end
            end else begin
                send_request(MODE_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
            end
        end
    endtask

    task automatic test_directed;
        begin
            send_request(MODE_ALLOC, 0, 1023);
            send_request(MODE_ALLOC, 2047, 0);
            send_request(MODE_ALLOC, 1025, 0);
            send_request(MODE_ALLOC, 1024, 0);
            send_request(MODE_ALLOC, 1, 0);
            send_request(MODE_FREE, 0, 1023);
            send_request(MODE_FREE, 2047, 1000);
            send_request(MODE_ALLOC, 30, 0);
            send_request(MODE_ALLOC, 24, 0);
            send_request(MODE_FREE, 1024, 0);
            send_request(MODE_FREE, 3, 5);
            send_request(MODE_ALLOC, 4, 0);
            send_request(MODE_ALLOC, 4, 0);
            send_request(MODE_ALLOC, 4, 0);
            send_request(MODE_FREE, 4, 4);
            send_request(MODE_ALLOC, 5, 0);
            send_request(MODE_ALLOC, 3, 0);
            send_request(MODE_ALLOC, 1, 0);
            send_request(MODE_ALLOC, 1, 0);
            send_request(MODE_FREE, 1, 1023);
            send_request(MODE_FREE, 2047, 0);
            live_runs.delete();
        end
    endtask

    task automatic test_fill_and_drain;
        int idx;
        t_run_rec rec;
        begin
            send_request(MODE_FREE, 1024, 0);
            live_runs.delete();
            last_result.status = STATUS_OK;
            while (last_result.status == STATUS_OK) begin
                send_request(MODE_ALLOC, $urandom_range(8, 64), $urandom_range(0, 1023));
            end
            repeat (6) send_request(MODE_ALLOC, $urandom_range(1, 7), $urandom_range(0, 1023));
            wait_until_drained();
            while (live_runs.size() != 0) begin
                idx = $urandom_range(0, live_runs.size() - 1);
                rec = live_runs[idx];
                live_runs.delete(idx);
                send_request(MODE_FREE, rec.len, rec.first);
            end
            send_request(MODE_ALLOC, 1024, 0);
            send_request(MODE_FREE, 1024, 0);
            live_runs.delete();
        end
    endtask

    task automatic test_random_mix;
        begin
            for (int n = 0; n < 390; n++) begin
                send_random_request();
                if (n % 60 == 59) wait_until_drained();
            end
        end
    endtask

    task automatic test_back_to_back;
        begin
            no_idle = 1'b1;
            repeat (100) send_random_request();
            wait_until_drained();
            no_idle = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result: status %0d, run_start %0d",
                       rsp_ch.status, rsp_ch.run_start);
                fail_count++;
            end else begin
                oldest_reply = expected_replies.pop_front();
                if (rsp_ch.status !== oldest_reply.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           oldest_reply.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.run_start !== oldest_reply.run_start) begin
                    $error("run_start mismatch: expected %0d, actual %0d",
                           oldest_reply.run_start, rsp_ch.run_start);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge i_clk);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_ALLOC;
        req_ch.cell_count = '0;
        req_ch.start_cell = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_and_drain();
        test_random_mix();
        test_back_to_back();

        wait_until_drained();
        repeat (NUM_CELLS + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
